// ===== hdl/assert_macros.svh =====
// assertion helpers included by sha256_stream_hash.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== hdl/sha256_pkg.sv =====
`default_nettype none

package sha256_pkg;

  localparam int unsigned BlockBits = 512;
  localparam int unsigned Rounds    = 64;

  typedef logic [31:0] word_t;

  // round constants
  localparam word_t RoundK [Rounds] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  // initial hash values
  localparam word_t InitH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [7:0] PadByte = 8'h80;

  // rotate right by a constant amount
  function automatic word_t ror32(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sha256_stream_hash.sv =====
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+---------------------------------------
// in_      | input     | in_valid/in_stall  | in_req_type, in_message_byte
// out_     | output    | out_valid/out_stall| out_digest_word, out_word_index,
//          |           |                    | out_last_word
//
// a message byte is taken while in_stall is low; the 64th byte of a block starts a
// compression (64 rounds on the shared round unit plus the chaining add) while
// in_stall is high.
// end of message: padding bytes up to the block end, one or two compressions,
// then eight digest words, one per cycle without stall.
// rst_n is synchronous; it restores the initial hash values and empties the block.
// out_stall holds the current digest word in place; in_stall stays high meanwhile.
`default_nettype none
`include "assert_macros.svh"

module sha256_stream_hash (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_message_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic        fin_r, fin_nxt;
  logic        len_ok_r, len_ok_nxt;
  logic [sha256_pkg::BlockBits-1:0] blk_r, blk_nxt;
  sha256_pkg::word_t h_r [8];
  sha256_pkg::word_t h_nxt [8];
  sha256_pkg::word_t v_r [8];
  sha256_pkg::word_t v_nxt [8];

  logic        in_acc;
  logic        out_acc;
  logic        byte_wr;
  logic [7:0]  byte_val;
  logic [63:0] len_shift;
  logic [7:0]  pad_val;

  sha256_pkg::word_t w0, w1, w9, w14, s0, s1, w_new;
  sha256_pkg::word_t big0, big1, ch, maj, t1, t2;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // handshake and result port
  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = h_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

  // padding byte: zeros, then the big-endian bit count in the last eight slots
  assign len_shift = bits_r >> {~fill_r[2:0], 3'b000};
  assign pad_val   = (len_ok_r && fill_r >= 6'd56) ? len_shift[7:0] : 8'h00;

  // message schedule taps from the 16-word window
  assign w0    = blk_r[511:480];
  assign w1    = blk_r[479:448];
  assign w9    = blk_r[223:192];
  assign w14   = blk_r[63:32];
  assign s0    = sha256_pkg::ror32(w1, 7) ^ sha256_pkg::ror32(w1, 18) ^ (w1 >> 3);
  assign s1    = sha256_pkg::ror32(w14, 17) ^ sha256_pkg::ror32(w14, 19) ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;

  // shared round unit
  assign big1 = sha256_pkg::ror32(v_r[4], 6) ^ sha256_pkg::ror32(v_r[4], 11)
              ^ sha256_pkg::ror32(v_r[4], 25);
  assign ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1   = v_r[7] + big1 + ch + sha256_pkg::RoundK[rnd_r] + w0;
  assign big0 = sha256_pkg::ror32(v_r[0], 2) ^ sha256_pkg::ror32(v_r[0], 13)
              ^ sha256_pkg::ror32(v_r[0], 22);
  assign maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2   = big0 + maj;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    rnd_nxt    = rnd_r;
    idx_nxt    = idx_r;
    bits_nxt   = bits_r;
    fin_nxt    = fin_r;
    len_ok_nxt = len_ok_r;
    blk_nxt    = blk_r;
    h_nxt      = h_r;
    v_nxt      = v_r;
    byte_wr    = 1'b0;
    byte_val   = 8'h00;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          byte_wr = 1'b1;
          if (in_req_type) begin
            byte_val   = sha256_pkg::PadByte;
            fin_nxt    = 1'b1;
            len_ok_nxt = (fill_r < 6'd56);
            state_nxt  = ST_PAD;
          end else begin
            byte_val = in_message_byte;
            bits_nxt = bits_r + 64'd8;
          end
        end
      end
      ST_PAD: begin
        byte_wr  = 1'b1;
        byte_val = pad_val;
      end
      ST_ROUND: begin
        blk_nxt  = {blk_r[479:0], w_new};
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (len_ok_r) begin
          idx_nxt   = 3'd0;
          state_nxt = ST_OUT;
        end else begin
          len_ok_nxt = 1'b1;
          state_nxt  = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            h_nxt      = sha256_pkg::InitH;
            bits_nxt   = 64'd0;
            fin_nxt    = 1'b0;
            len_ok_nxt = 1'b0;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // byte insertion into the block shift line; a full block starts the rounds
    if (byte_wr) begin
      blk_nxt  = {blk_r[503:0], byte_val};
      fill_nxt = fill_r + 6'd1;
      if (fill_r == 6'd63) begin
        rnd_nxt   = 6'd0;
        v_nxt     = h_r;
        state_nxt = ST_ROUND;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= 6'd0;
      rnd_r    <= 6'd0;
      idx_r    <= 3'd0;
      bits_r   <= 64'd0;
      fin_r    <= 1'b0;
      len_ok_r <= 1'b0;
      h_r      <= sha256_pkg::InitH;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      rnd_r    <= rnd_nxt;
      idx_r    <= idx_nxt;
      bits_r   <= bits_nxt;
      fin_r    <= fin_nxt;
      len_ok_r <= len_ok_nxt;
      h_r      <= h_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    v_r   <= v_nxt;
  end

  // checks
  `ASSERT_NEVER(a_out_while_in, clk, rst_n, out_valid && !in_stall, "input open while digest out")
  `ASSERT_AT(a_last_round, clk, rst_n, (state_r == ST_ROUND && rnd_r == 6'd63) |=> (state_r == ST_ADD), "round count overrun")
  `ASSERT_AT(a_out_empty, clk, rst_n, (state_r == ST_OUT) |-> (fill_r == 6'd0 && fin_r), "digest out with partial block")
  `ASSERT_AT(a_end_pads, clk, rst_n, (in_acc && in_req_type) |=> (state_r == ST_PAD || state_r == ST_ROUND), "end of message not padded")

endmodule

`default_nettype wire
